// ===== rtl/core/sla_pkg.sv =====
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants for the serial line assembler: store geometry,
// character codes, result status codes and the config bundle.
// ----------------------------------------------------------------------------
package sla_pkg;

    // Line store geometry
    localparam int LINE_CAPACITY = 64;
    localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    // Configuration register
    localparam int LEN_W     = 7;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int LEN_RESET = 64;
    localparam int LEN_MIN   = 2;

    // Common width for length compares
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // Result status codes
    localparam logic [1:0] ST_LINE  = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    // Register index of max_line_len
    localparam logic REG_MAX_LEN = 1'b0;

    // Config bundle from the register block to the controller
    typedef struct packed {
        logic [LEN_W-1:0] lim;   // clamped line limit
    } t_cfg;

endpackage

// ===== rtl/core/sla_rx_if.sv =====
// ----------------------------------------------------------------------------
// sla_rx_if
// Received-byte channel: valid/ready handshake, one byte per word.
// ----------------------------------------------------------------------------
interface sla_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sla_line_if.sv =====
// ----------------------------------------------------------------------------
// sla_line_if
// Line output channel: valid/ready handshake, one line byte or notice per word.
// ----------------------------------------------------------------------------
interface sla_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_char;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output line_char, output status, output last,
                    input ready);
    modport sink   (input valid, input line_char, input status, input last,
                    output ready);
endinterface

// ===== rtl/core/serial_line_assembler.sv =====
// ----------------------------------------------------------------------------
// serial_line_assembler
// Line editor with backspace: gathers received bytes into a line store and
// emits each completed line as a run of words.
//
//   channel   dir   handshake          payload
//   i_rx      in    valid/ready        rx_byte[7:0]
//   o_line    out   valid/ready        line_char[7:0], status[1:0], last
//   APB       in    psel/penable/rdy   max_line_len at byte address 0
//
// No new byte is taken while a line is read out. The stored bytes of a
// line are read one per cycle, while the output does not stall, through the
// single read port of the line store.
// Reset (synchronous, active low) clears the fill count and discard flag and
// sets max_line_len to 64; the line store holds no reset value.
// A stalled output holds the readout; a new byte is taken only once the
// output register is free or drains in the same cycle.
// ----------------------------------------------------------------------------
module serial_line_assembler import sla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sla_rx_if.sink            i_rx,
    sla_line_if.source        o_line,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg              cfg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Configuration register
    sla_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Editing and readout sequencer
    sla_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_rx_valid   (i_rx.valid),
        .o_rx_ready   (i_rx.ready),
        .i_rx_byte    (i_rx.rx_byte),
        .o_out_valid  (o_line.valid),
        .i_out_ready  (o_line.ready),
        .o_out_char   (o_line.line_char),
        .o_out_status (o_line.status),
        .o_out_last   (o_line.last),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    // Line store
    sla_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== rtl/core/sla_ram.sv =====
// ----------------------------------------------------------------------------
// sla_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/sla_cfg.sv =====
// ----------------------------------------------------------------------------
// sla_cfg
// APB register block holding max_line_len; supplies the clamped line limit.
// ----------------------------------------------------------------------------
module sla_cfg import sla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [LEN_W-1:0] r_max_len;
    logic             wr_hit;

    // Register index is the word address
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= LEN_W'(LEN_RESET);
        end else if (wr_hit) begin
            r_max_len <= pwdata[LEN_W-1:0];
        end
    end

    // Readback; beyond the register list reads zero
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_LEN) begin
            prdata = APB_DW'(r_max_len);
        end
    end

    assign pready = 1'b1;

    // Sizes below the minimum act as the minimum
    assign o_cfg.lim = (r_max_len < LEN_W'(LEN_MIN)) ? LEN_W'(LEN_MIN) : r_max_len;

endmodule

// ===== rtl/core/sla_ctrl.sv =====
// ----------------------------------------------------------------------------
// sla_ctrl
// Line editing sequencer: edits the fill count and store on each received
// byte, then walks the stored line out through one shared read counter.
// ----------------------------------------------------------------------------
module sla_ctrl import sla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    // received bytes
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    // line words
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_char,
    output logic [1:0]        o_out_status,
    output logic              o_out_last,
    // line store
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_fill;
    logic             r_discard;
    logic [CNT_W-1:0] r_iss_idx;
    logic [CNT_W-1:0] r_run_n;
    logic             r_trunc;
    logic             r_pend;
    logic             r_pend_last;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic [1:0]       r_out_status;
    logic             r_out_last;

    logic             rx_fire;
    logic             is_term;
    logic             is_erase;
    logic             is_print;
    logic             store_full;
    logic             ovf_fire;
    logic             out_free;
    logic             load_out;
    logic             rd_en;
    logic             len_ge;
    logic [CNT_W-1:0] run_n;
    logic [CNT_W-1:0] iss_next;

    // Byte classes
    assign is_term    = (i_rx_byte == CH_LF) || (i_rx_byte == CH_CR);
    assign is_erase   = (i_rx_byte == CH_BS) || (i_rx_byte == CH_DEL);
    assign is_print   = (i_rx_byte >= CH_SPACE) && (i_rx_byte < CH_DEL);
    assign store_full = (r_fill == CNT_W'(STORE_DEPTH));

    // Handshakes
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_rx_ready = (r_state == S_IDLE) && out_free;
    assign rx_fire    = i_rx_valid && o_rx_ready;

    // Byte that raises the overflow notice
    assign ovf_fire = rx_fire && !r_discard && !is_term && !is_erase && store_full;

    // Run length on a terminator: truncate at limit - 1
    assign len_ge = CMP_W'(r_fill) >= CMP_W'(i_cfg.lim);
    assign run_n  = len_ge ? CNT_W'(i_cfg.lim - LEN_W'(1)) : r_fill;

    // Read issue: one address per cycle, held back while a word waits
    assign iss_next = r_iss_idx + CNT_W'(1);
    assign load_out = r_pend && out_free;
    assign rd_en    = (r_state == S_READ) && (r_iss_idx != r_run_n) && (!r_pend || load_out);

    // Store ports
    assign o_wr_en   = rx_fire && (r_state == S_IDLE) && !r_discard && !is_term
                       && !is_erase && !store_full && is_print;
    assign o_wr_addr = r_fill[ADDR_W-1:0];
    assign o_wr_data = i_rx_byte;
    assign o_rd_en   = rd_en;
    assign o_rd_addr = r_iss_idx[ADDR_W-1:0];

    // Sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_discard   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_iss_idx   <= '0;
            r_run_n     <= '0;
        end else begin
            // output word taken, nothing new behind it
            if (r_out_valid && i_out_ready && !load_out && !ovf_fire) begin
                r_out_valid <= 1'b0;
            end
            // stored byte moves into the output register
            if (load_out) begin
                r_out_valid  <= 1'b1;
                r_out_char   <= i_rd_data;
                r_out_status <= r_trunc ? ST_TRUNC : ST_LINE;
                r_out_last   <= r_pend_last;
            end
            // read pipeline
            if (rd_en) begin
                r_pend      <= 1'b1;
                r_pend_last <= (iss_next == r_run_n);
                r_iss_idx   <= iss_next;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (rx_fire) begin
                        if (r_discard) begin
                            if (is_term) begin
                                r_discard <= 1'b0;
                            end
                        end else if (is_term) begin
                            r_fill <= '0;
                            if (r_fill != '0) begin
                                r_run_n   <= run_n;
                                r_trunc   <= len_ge;
                                r_iss_idx <= '0;
                                r_state   <= S_READ;
                            end
                        end else if (is_erase) begin
                            if (r_fill != '0) begin
                                r_fill <= r_fill - CNT_W'(1);
                            end
                        end else if (store_full) begin
                            // overflow notice, then skip to next terminator
                            r_fill       <= '0;
                            r_discard    <= 1'b1;
                            r_out_valid  <= 1'b1;
                            r_out_char   <= '0;
                            r_out_status <= ST_OVF;
                            r_out_last   <= 1'b1;
                        end else if (is_print) begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                    end
                end
                S_READ: begin
                    if ((r_iss_idx == r_run_n) && !r_pend) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

`ifndef SYNTHESIS
    // fill count stays within the store
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    // a readout run is never empty
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_run_n != '0))
        else $error("readout with empty run");

    // read counter never passes the run length
    a_iss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_iss_idx <= r_run_n))
        else $error("read counter past run length");

    // pending read data only during readout
    a_pend_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_READ))
        else $error("pending read outside readout");

    // no byte is taken during readout
    a_no_rx_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !o_rx_ready)
        else $error("byte accepted during readout");
`endif

endmodule
